>>> rtl/msaa_pkg.sv
// ============================================================================
// msaa_pkg
// Shared types and constants for the multisample box resolve.
// ============================================================================
package msaa_pkg;

    // Channel and sum widths, sized for the largest supported scale of 8
    localparam int CH_W   = 8;
    localparam int NUM_CH = 4;
    localparam int SPAN_W = 11;     // up to 8 samples of 255
    localparam int SUM_W  = 14;     // up to 64 samples of 255
    localparam int ROW_W  = 10;
    localparam int COL_W  = 10;

    localparam int MAX_HEIGHT      = 1024;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_SCALE   = 8;

    // Configuration registers
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_REG_W  = 11;
    localparam int SCALE_REG_W = 4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;

    localparam logic [CFG_REG_W-1:0]   RST_WIDTH  = 11'd640;
    localparam logic [CFG_REG_W-1:0]   RST_HEIGHT = 11'd480;
    localparam logic [SCALE_REG_W-1:0] RST_SCALE  = 4'd1;

    // One horizontal span of a square, handed from front to back
    typedef struct packed {
        logic [NUM_CH-1:0][SPAN_W-1:0] span;
        logic [ROW_W-1:0]              row;
        logic                          first_sub;   // top sub-row of the square
        logic                          last_sub;    // bottom sub-row of the square
        logic                          frame_last;  // last pixel of the frame
    } msaa_span_t;

endpackage

>>> rtl/msaa_front.sv
// ============================================================================
// msaa_front
// Sample intake: tracks the sample position and sums each horizontal span.
// ============================================================================
module msaa_front #(
    parameter int X_W  = 10,
    parameter int SX_W = 3
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        restart,
    input  logic [X_W-1:0]                              w_last,
    input  logic [msaa_pkg::ROW_W-1:0]                  h_last,
    input  logic [SX_W-1:0]                             s_last,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [msaa_pkg::NUM_CH-1:0][msaa_pkg::CH_W-1:0] sample,
    input  logic                                        fifo_full,
    output logic                                        push,
    output logic [X_W-1:0]                              push_x,
    output msaa_pkg::msaa_span_t                        push_span
);
    import msaa_pkg::*;

    logic [SX_W-1:0]  sx_reg, sx_next;
    logic [X_W-1:0]   x_reg, x_next;
    logic [SX_W-1:0]  sy_reg, sy_next;
    logic [ROW_W-1:0] y_reg, y_next;
    logic [NUM_CH-1:0][SPAN_W-1:0] span_reg, span_next;
    logic accept;
    logic span_end;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign span_end = (sx_reg == s_last);
    assign push     = accept && span_end;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (sx_reg == '0)
                span_next[c] = SPAN_W'(sample[c]);
            else
                span_next[c] = span_reg[c] + SPAN_W'(sample[c]);
        end
    end

    always_comb
    begin
        sx_next = sx_reg;
        x_next  = x_reg;
        sy_next = sy_reg;
        y_next  = y_reg;
        if (accept)
        begin
            if (!span_end)
                sx_next = sx_reg + 1'b1;
            else
            begin
                sx_next = '0;
                if (x_reg != w_last)
                    x_next = x_reg + 1'b1;
                else
                begin
                    x_next = '0;
                    if (sy_reg != s_last)
                        sy_next = sy_reg + 1'b1;
                    else
                    begin
                        sy_next = '0;
                        y_next  = (y_reg == h_last) ? '0 : y_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign push_x               = x_reg;
    assign push_span.span       = span_next;
    assign push_span.row        = y_reg;
    assign push_span.first_sub  = (sy_reg == '0);
    assign push_span.last_sub   = (sy_reg == s_last);
    assign push_span.frame_last = (x_reg == w_last) && (y_reg == h_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg   <= '0;
            x_reg    <= '0;
            sy_reg   <= '0;
            y_reg    <= '0;
            span_reg <= '0;
        end
        else if (restart)
        begin
            sx_reg   <= '0;
            x_reg    <= '0;
            sy_reg   <= '0;
            y_reg    <= '0;
            span_reg <= '0;
        end
        else
        begin
            sx_reg <= sx_next;
            x_reg  <= x_next;
            sy_reg <= sy_next;
            y_reg  <= y_next;
            if (accept)
                span_reg <= span_next;
        end
    end

endmodule

>>> rtl/msaa_fifo.sv
// ============================================================================
// msaa_fifo
// Small span queue between intake and line-buffer update.
// ============================================================================
module msaa_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/msaa_back.sv
// ============================================================================
// msaa_back
// Line-buffer accumulate, divide by scale squared, and output register.
// ============================================================================
module msaa_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int X_W       = 10,
    parameter int DIV_W     = 8
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          q_empty,
    input  logic [X_W-1:0]                                q_x,
    input  msaa_pkg::msaa_span_t                          q_span,
    output logic                                          q_pop,
    input  logic [DIV_W-1:0]                              divisor,
    input  logic                                          div_one,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [msaa_pkg::NUM_CH-1:0][msaa_pkg::CH_W-1:0] pixel,
    output logic [msaa_pkg::COL_W-1:0]                    pixel_column,
    output logic [msaa_pkg::ROW_W-1:0]                    pixel_row,
    output logic                                          frame_done
);
    import msaa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                         state_reg;
    logic [X_W-1:0]                 x_reg;
    msaa_span_t                     ent_reg;
    logic [NUM_CH-1:0][SUM_W-1:0]   mem [MAX_WIDTH];
    logic [NUM_CH-1:0][SUM_W-1:0]   rd_data_reg;
    logic [NUM_CH-1:0][SUM_W-1:0]   total;
    logic [NUM_CH-1:0][SUM_W-1:0]   rem_reg;
    logic [NUM_CH-1:0][CH_W-1:0]    quo_reg;
    logic [NUM_CH-1:0]              fits;
    logic [SUM_W-1:0]               shifted;
    logic [2:0]                     step_reg;
    logic                           mem_wr;

    assign q_pop  = (state_reg == ST_IDLE) && !q_empty;
    assign mem_wr = (state_reg == ST_SUM);

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            total[c] = (ent_reg.first_sub ? '0 : rd_data_reg[c]) + SUM_W'(ent_reg.span[c]);
        end
    end

    // one restoring-division step per cycle, all four channels side by side
    assign shifted = SUM_W'(divisor) << step_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            fits[c] = (rem_reg[c] >= shifted);
        end
    end

    // line buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[x_reg] <= total;
        rd_data_reg <= mem[x_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            x_reg        <= '0;
            ent_reg      <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            step_reg     <= '0;
            m_tvalid     <= 1'b0;
            pixel        <= '0;
            pixel_column <= '0;
            pixel_row    <= '0;
            frame_done   <= 1'b0;
        end
        else
        begin
            // in ST_OUT the beat is either reloaded or still held
            if (m_tvalid && m_tready && state_reg != ST_OUT)
                m_tvalid <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        x_reg     <= q_x;
                        ent_reg   <= q_span;
                        state_reg <= q_span.first_sub ? ST_SUM : ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    if (!ent_reg.last_sub)
                        state_reg <= ST_IDLE;
                    else if (div_one)
                    begin
                        for (int c = 0; c < NUM_CH; c++)
                            quo_reg[c] <= total[c][CH_W-1:0];
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        rem_reg   <= total;
                        quo_reg   <= '0;
                        step_reg  <= 3'd7;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        if (fits[c])
                        begin
                            rem_reg[c]           <= rem_reg[c] - shifted;
                            quo_reg[c][step_reg] <= 1'b1;
                        end
                    end
                    if (step_reg == '0)
                        state_reg <= ST_OUT;
                    else
                        step_reg <= step_reg - 1'b1;
                end
                ST_OUT:
                begin
                    if (!m_tvalid || m_tready)
                    begin
                        m_tvalid     <= 1'b1;
                        pixel        <= quo_reg;
                        pixel_column <= COL_W'(x_reg);
                        pixel_row    <= ent_reg.row;
                        frame_done   <= ent_reg.frame_last;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/msaa_box_resolve_unit.sv
// ============================================================================
// msaa_box_resolve_unit
// Box-filter multisample resolve: scale x scale sample squares to pixels.
// ============================================================================
// Samples arrive in raster order of the supersampled frame, one RGBA beat per
// sample, with screen_width * sample_scale samples per row. Each square of
// sample_scale by sample_scale samples becomes one 8-bit RGBA pixel, the exact
// channel sums divided by sample_scale squared and truncated, sent with its
// column and row once the lower right sample of the square is in; m_tlast
// marks the last pixel of the frame. Any write to a valid register restarts
// the frame. Rate: the intake takes one sample a cycle while the span queue is
// not full and closes a span of sample_scale samples per row of a square; the
// back end handles a span of the top sub-row without a line-buffer read, other
// sub-rows with one, and the bottom sub-row with the read, then an 8-step
// divider, then a load of the output register. With scale 1 no read or division
// is needed; with scale 3 or more the intake runs at one sample a cycle except
// on the bottom sub-row, which the divider slows. A four-deep span queue lets
// intake and back end stall apart. The line buffer needs no clearing after
// reset: each entry is written by the top sub-row of a square row before it
// is read.
// ============================================================================
module msaa_box_resolve_unit #(
    parameter int MAX_WIDTH = msaa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_SCALE = msaa_pkg::DEF_MAX_SCALE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // red, green, blue, alpha
    // pixel stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [55:0]                       m_tdata,  // red, green, blue, alpha,
                                                        // column, row, zero pad
    output logic                              m_tlast,  // frame_done
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msaa_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [msaa_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [msaa_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import msaa_pkg::*;

    localparam int X_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SX_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int S_W   = $clog2(MAX_SCALE + 1);
    localparam int DIV_W = 2 * S_W;
    localparam int Q_W   = X_W + $bits(msaa_span_t);

    logic [CFG_REG_W-1:0]   width_reg;
    logic [CFG_REG_W-1:0]   height_reg;
    logic [SCALE_REG_W-1:0] scale_reg;
    logic                   cfg_wr;
    logic                   restart;
    logic [1:0]             reg_idx;

    logic [X_W-1:0]   w_last;
    logic [ROW_W-1:0] h_last;
    logic [S_W-1:0]   s_eff;
    logic [SX_W-1:0]  s_last;
    logic [DIV_W-1:0] divisor;
    logic             div_one;

    logic [NUM_CH-1:0][CH_W-1:0] sample;
    logic [NUM_CH-1:0][CH_W-1:0] pixel;
    logic [COL_W-1:0]            pixel_column;
    logic [ROW_W-1:0]            pixel_row;

    logic             push, pop, q_full, q_empty;
    logic [X_W-1:0]   push_x;
    msaa_span_t       push_span;
    logic [Q_W-1:0]   q_out;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    // writes to an unmapped slot are dropped and do not restart the frame
    assign restart = cfg_wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT ||
                                reg_idx == REG_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            scale_reg  <= RST_SCALE;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_WIDTH:  width_reg  <= pwdata[CFG_REG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_REG_W-1:0];
                REG_SCALE:  scale_reg  <= pwdata[SCALE_REG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WIDTH:  prdata = CFG_DATA_W'(width_reg);
            REG_HEIGHT: prdata = CFG_DATA_W'(height_reg);
            REG_SCALE:  prdata = CFG_DATA_W'(scale_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- effective geometry ----------------
    // zero counts as one, oversize values clamp to the supported maximum
    always_comb
    begin
        if (width_reg == '0)
            w_last = '0;
        else if (32'(width_reg) > MAX_WIDTH)
            w_last = X_W'(MAX_WIDTH - 1);
        else
            w_last = X_W'(width_reg - 1'b1);

        if (height_reg == '0)
            h_last = '0;
        else if (32'(height_reg) > MAX_HEIGHT)
            h_last = ROW_W'(MAX_HEIGHT - 1);
        else
            h_last = ROW_W'(height_reg - 1'b1);

        if (scale_reg == '0)
            s_eff = S_W'(1);
        else if (32'(scale_reg) > MAX_SCALE)
            s_eff = S_W'(MAX_SCALE);
        else
            s_eff = S_W'(scale_reg);
    end

    assign s_last  = SX_W'(s_eff - 1'b1);
    assign divisor = DIV_W'(s_eff) * DIV_W'(s_eff);
    assign div_one = (s_eff == S_W'(1));

    // ---------------- datapath ----------------
    assign sample = s_tdata;

    msaa_front #(
        .X_W  (X_W),
        .SX_W (SX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .w_last    (w_last),
        .h_last    (h_last),
        .s_last    (s_last),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sample    (sample),
        .fifo_full (q_full),
        .push      (push),
        .push_x    (push_x),
        .push_span (push_span)
    );

    msaa_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (4)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_x, push_span}),
        .pop       (pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    msaa_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .X_W       (X_W),
        .DIV_W     (DIV_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_x          (q_out[Q_W-1 -: X_W]),
        .q_span       (q_out[$bits(msaa_span_t)-1:0]),
        .q_pop        (pop),
        .divisor      (divisor),
        .div_one      (div_one),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .pixel        (pixel),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .frame_done   (m_tlast)
    );

    assign m_tdata = {4'b0, pixel_row, pixel_column, pixel};

endmodule

>>> rtl/msaa_chk.sv
// ============================================================================
// msaa_chk
// Port-level checks for the multisample resolve, bound to the top level.
// ============================================================================
module msaa_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    logic       out_beat;
    logic [9:0] last_col_reg;
    logic       done_seen_reg;

    assign out_beat = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg  <= 10'h3FF;
            done_seen_reg <= 1'b0;
        end
        else if (out_beat)
        begin
            last_col_reg  <= m_tdata[41:32];
            done_seen_reg <= m_tlast;
        end
    end

    // a stalled pixel beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("pixel beat changed while stalled");

    // pixels leave in raster order: column steps by one or restarts a row
    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> m_tdata[41:32] == 10'd0 || m_tdata[41:32] == 10'(last_col_reg + 10'd1))
        else $error("pixel column out of raster order");

    // the pixel after end of frame opens the next frame
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && done_seen_reg |-> m_tdata[41:32] == 10'd0 && m_tdata[51:42] == 10'd0)
        else $error("frame did not restart at origin");

    // screen width register reads back what was written
    a_width_rb: assert property (@(posedge clk) disable iff (!rst_n)
        $past(psel && penable && pwrite && pready && paddr[3:2] == 2'd0) &&
        paddr[3:2] == 2'd0 |-> prdata[10:0] == $past(pwdata[10:0]))
        else $error("width register readback mismatch");

endmodule

bind msaa_box_resolve_unit msaa_chk u_msaa_chk (.*);

>>> tb/tb_msaa_box_resolve_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_msaa_box_resolve_unit
// Self-checking bench for the multisample box resolve.
// ============================================================================
// Samples go in on the s_ stream, and the bench predicts each pixel the block
// owes from its own copy of the line buffer, the sample position and the
// register shadow. Every pixel beat on the m_ stream is checked field by field
// against the oldest predicted pixel. The bench runs directed corner samples,
// out-of-range register values, register writes between and inside frames,
// oversize width and height registers, and then random frames of random small
// sizes. Both streams idle at random. A watchdog ends the run when no beat
// moves for too long.
// ============================================================================
module tb_msaa_box_resolve_unit;
    import msaa_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 6;
    // Worst quiet stretch of a correct run comes from the settle pause, the
    // longest receiver stall and bottom sub-row spans through the divider
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 100;    // span queue plus divider, with margin
    localparam int RANDOM_ITEMS   = 140;
    localparam int MAX_FRAME_LEN  = 72;     // random frames stay small
    localparam int CLAMP_ITEMS    = 40;

    // Index just past the register list, must be ignored
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             done;
    } pixel_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // red, green, blue, alpha
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // red, green, blue, alpha, column, row, zero pad
    logic        m_tlast;           // frame_done
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr  = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic        pready;

    // Register shadow, as written (clamping happens at use)
    logic [CFG_REG_W-1:0]   cfg_width  = RST_WIDTH;
    logic [CFG_REG_W-1:0]   cfg_height = RST_HEIGHT;
    logic [SCALE_REG_W-1:0] cfg_scale  = RST_SCALE;

    // Resolve state
    logic [SUM_W-1:0]  line_sum [DEF_MAX_WIDTH][NUM_CH];
    logic [SPAN_W-1:0] span_acc [NUM_CH] = '{default: '0};
    int                samp_col = 0;
    int                samp_row = 0;

    pixel_t pixel_q [$];
    pixel_t head_px;

    int err_count      = 0;
    int samples_sent   = 0;
    int pixels_checked = 0;
    int frame_ends     = 0;
    int cfg_writes     = 0;
    int random_samples = 0;
    int stall_cycles   = 0;
    int tx_gap_pct     = 20;
    int rx_stall_pct   = 20;
    int rx_hold        = 0;

    msaa_box_resolve_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Effective sizes: zero counts as one, too large counts as the maximum
    // ------------------------------------------------------------------------
    function automatic int eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int eff_height();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return cfg_height;
    endfunction

    function automatic int eff_scale();
        if (cfg_scale == 0) return 1;
        if (cfg_scale > DEF_MAX_SCALE) return DEF_MAX_SCALE;
        return cfg_scale;
    endfunction

    function automatic int frame_len();
        return eff_width() * eff_height() * eff_scale() * eff_scale();
    endfunction

    // ------------------------------------------------------------------------
    // Box filter predictor: one accepted sample, zero or one pixel
    // ------------------------------------------------------------------------
    function automatic void resolve_sample(input logic [31:0] smp);
        int w;
        int h;
        int s;
        int x;
        int sx;
        int y;
        int sy;
        logic [CH_W-1:0] quot [NUM_CH];
        pixel_t px;
        w = eff_width();
        h = eff_height();
        s = eff_scale();
        if (samp_col >= w * s) samp_col = 0;
        if (samp_row >= h * s) samp_row = 0;
        x  = samp_col / s;
        sx = samp_col % s;
        y  = samp_row / s;
        sy = samp_row % s;

        if (sx == 0) span_acc = '{default: '0};
        for (int c = 0; c < NUM_CH; c++)
            span_acc[c] = span_acc[c] + smp[c*CH_W +: CH_W];

        // Span closes: top sub-row writes the line buffer, the rest add to it
        if (sx == s - 1)
        begin
            for (int c = 0; c < NUM_CH; c++)
                if (sy == 0) line_sum[x][c] = SUM_W'(span_acc[c]);
                else         line_sum[x][c] = line_sum[x][c] + span_acc[c];
            if (sy == s - 1)
            begin
                for (int c = 0; c < NUM_CH; c++)
                    quot[c] = CH_W'(line_sum[x][c] / (s * s));
                px.red    = quot[0];
                px.green  = quot[1];
                px.blue   = quot[2];
                px.alpha  = quot[3];
                px.column = COL_W'(x);
                px.row    = ROW_W'(y);
                px.done   = (x == w - 1) && (y == h - 1);
                pixel_q   = {pixel_q, px};
            end
        end

        samp_col++;
        if (samp_col >= w * s)
        begin
            samp_col = 0;
            samp_row++;
            if (samp_row >= h * s) samp_row = 0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    // Gap with the given percent chance; when there is one, mostly short, rarely long
    function automatic int pick_gap(input int pct);
        int r;
        if ($urandom_range(0, 99) >= pct) return 0;
        r = $urandom_range(0, 9);
        if (r < 7) return $urandom_range(1, 3);
        if (r < 9) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Register value with random junk above the field now and then
    function automatic logic [31:0] with_junk(input logic [31:0] value, input int bits);
        if ($urandom_range(0, 3) != 0) return value;
        return ($urandom << bits) | value;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("pixel %0d %s: got %0d, expected %0d",
                                      pixels_checked, name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pixel_q.size() == 0)
            begin
                report_mismatch($sformatf("pixel beat with nothing expected, tdata %h last %b",
                                          m_tdata, m_tlast));
            end
            else
            begin
                head_px = pixel_q.pop_front();
                check_field("red",    m_tdata[7:0],   head_px.red);
                check_field("green",  m_tdata[15:8],  head_px.green);
                check_field("blue",   m_tdata[23:16], head_px.blue);
                check_field("alpha",  m_tdata[31:24], head_px.alpha);
                check_field("column", m_tdata[41:32], head_px.column);
                check_field("row",    m_tdata[51:42], head_px.row);
                check_field("pad",    m_tdata[55:52], 0);
                check_field("frame_done", m_tlast,    head_px.done);
                if (head_px.done) frame_ends++;
            end
            pixels_checked++;
        end
    end

    // Receiver: hold tready low for random stretches
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_hold  <= pick_gap(rx_stall_pct);
        end
    end

    // Watchdog: no beat on either stream for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no beat for %0d cycles, %0d pixels still expected",
                         stall_cycles, pixel_q.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [31:0] smp);
        int gap;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge clk); while (!s_tready);
        resolve_sample(smp);
        samples_sent++;
    endtask

    // Sender pause until the block has handed over every owed pixel
    task automatic hold_for_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
    endtask

    task automatic stream_samples(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 299) == 0) hold_for_drain();
            send_sample(rand_sample());
        end
    endtask

    // Drain, then let spans that owe no pixel clear the back end
    task automatic wait_idle();
        hold_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup beat then access beat; only called while idle
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_WIDTH:  cfg_width  = value[CFG_REG_W-1:0];
            REG_HEIGHT: cfg_height = value[CFG_REG_W-1:0];
            REG_SCALE:  cfg_scale  = value[SCALE_REG_W-1:0];
            default: ;
        endcase
        // A valid register write starts a new frame
        if (idx != REG_NONE)
        begin
            samp_col = 0;
            samp_row = 0;
            span_acc = '{default: '0};
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
    endtask

    task automatic set_size(input int w, input int h, input int s);
        reg_write(REG_WIDTH,  w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_SCALE,  s);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset setting (scale 1): samples pass straight through
    task automatic test_corner_samples();
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h55AA_55AA);
        send_sample(32'hAA55_AA55);
        send_sample(32'h0000_00FF);
        send_sample(32'hFF00_0000);
        wait_idle();
    endtask

    // Two 2x2 squares: all full scale, then one sample short of it (truncation)
    task automatic test_box_average();
        set_size(2, 1, 2);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'hFEFE_FEFE);
        wait_idle();
    endtask

    // Zero sizes count as one; scales above the maximum count as the maximum
    task automatic test_out_of_range_config();
        set_size(0, 0, 0);
        send_sample(32'h0102_0304);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        wait_idle();
        reg_write(REG_SCALE, 15);
        stream_samples(frame_len());
        wait_idle();
        set_size(2, 1, DEF_MAX_SCALE);
        stream_samples(frame_len());
        wait_idle();
    endtask

    // A write past the register list leaves the frame position alone
    task automatic test_ignored_register();
        set_size(3, 2, 2);
        stream_samples(10);
        wait_idle();
        reg_write(REG_NONE, $urandom);
        stream_samples(frame_len() - 10);
        wait_idle();
    endtask

    // Rewriting a register mid-frame restarts the frame
    task automatic test_restart_on_write();
        stream_samples(7);
        wait_idle();
        reg_write(REG_HEIGHT, cfg_height);
        stream_samples(frame_len());
        wait_idle();
    endtask

    // Sender holds off mid-frame until every owed pixel is out
    task automatic test_drain_pause();
        tx_gap_pct   = 0;
        rx_stall_pct = 60;
        set_size(4, 2, 3);
        stream_samples(30);
        hold_for_drain();
        stream_samples(frame_len() - 30);
        wait_idle();
    endtask

    // Width register above the maximum: start of a very wide row
    task automatic test_wide_rows();
        tx_gap_pct   = 0;
        rx_stall_pct = 10;
        set_size(2047, 1, 1);
        stream_samples(CLAMP_ITEMS);
        wait_idle();
    endtask

    // Height register above the maximum: top of a very tall frame
    task automatic test_tall_frames();
        tx_gap_pct   = 10;
        rx_stall_pct = 0;
        set_size(1, MAX_HEIGHT + 1, 1);
        stream_samples(CLAMP_ITEMS);
        wait_idle();
    endtask

    // Random small frames: whole frames mostly, a cut-off frame now and then
    task automatic test_random_frames();
        int s_pick;
        int w_pick;
        int h_pick;
        int es;
        int flen;
        int n;
        while (random_samples < RANDOM_ITEMS)
        begin
            tx_gap_pct   = pick_pct();
            rx_stall_pct = pick_pct();
            case ($urandom_range(0, 9))
                0:       s_pick = 0;
                1:       s_pick = $urandom_range(DEF_MAX_SCALE + 1, 15);
                default: s_pick = $urandom_range(1, DEF_MAX_SCALE);
            endcase
            reg_write(REG_SCALE, with_junk(s_pick, SCALE_REG_W));
            es = eff_scale();
            do
            begin
                w_pick = $urandom_range(1, 5);
                h_pick = $urandom_range(1, 3);
            end
            while (w_pick * h_pick * es * es > MAX_FRAME_LEN);
            if ($urandom_range(0, 9) == 0) w_pick = 0;
            if ($urandom_range(0, 9) == 0) h_pick = 0;
            reg_write(REG_WIDTH,  with_junk(w_pick, CFG_REG_W));
            reg_write(REG_HEIGHT, with_junk(h_pick, CFG_REG_W));
            flen = frame_len();
            n = $urandom_range(1, 2) * flen;
            if (flen > 1 && $urandom_range(0, 2) == 0) n += $urandom_range(1, flen - 1);
            // keep the total near the sample budget
            if (n > RANDOM_ITEMS - random_samples)
                n = RANDOM_ITEMS - random_samples;
            stream_samples(n);
            random_samples += n;
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_samples();
        test_box_average();
        test_out_of_range_config();
        test_ignored_register();
        test_restart_on_write();
        test_drain_pause();
        test_wide_rows();
        test_tall_frames();
        test_random_frames();
        wait_idle();

        $display("Run: %0d samples in, %0d pixels checked, %0d frame ends, %0d register writes",
                 samples_sent, pixels_checked, frame_ends, cfg_writes);
        $display("Scales 0 to 15, sizes 0 to 2047 with clamping, mid-frame writes and drains");
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
